[rtl/fsce_pkg.sv]
package fsce_pkg;

    // argument and decimal digit store sizes
    localparam int ARG_W      = 32;
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int IDX_W      = 4;

    // characters the formatter recognises or produces
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_LC_L  = 8'h6C;
    localparam logic [7:0] CH_LC_U  = 8'h75;
    localparam logic [7:0] CH_LC_D  = 8'h64;
    localparam logic [7:0] CH_LC_C  = 8'h63;
    localparam logic [7:0] CH_LC_X  = 8'h78;
    localparam logic [7:0] CH_UC_X  = 8'h58;

    localparam logic [3:0] LONG_WIDTH = 4'd4;
    localparam logic [3:0] NIB_MAX    = 4'd9;

    typedef struct packed {
        logic [7:0]       format_byte;
        logic [ARG_W-1:0] arg_value;
    } t_in;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_char;
    } t_out;

    // specification parser mode; the fourth code acts as plain text
    typedef enum logic [1:0] {
        M_PLAIN = 2'd0,
        M_PCT   = 2'd1,
        M_SPEC  = 2'd2
    } t_mode;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PRE  = 4'b0010,
        S_WAIT = 4'b0100,
        S_BODY = 4'b1000
    } t_state;

    // what the body of a request emits
    typedef enum logic [1:0] {
        K_CHAR = 2'd0,
        K_DEC  = 2'd1,
        K_HEX  = 2'd2
    } t_kind;

endpackage

[rtl/format_string_char_emitter.sv]
// A plain byte is sent as one character; a decimal argument first passes through the
// shift-and-add-3 converter, then goes out one digit place at a time.
// A byte with no output sends nothing, a newline sends CR then LF, hex sends its prefix
// if any and then its width in digits, decimal up to 10 digits (sign sent during conversion);
// no request is taken while one is in work, and output stalls hold the block.
// Reset (synchronous, active low) returns to plain text mode, width zero, no output.
module format_string_char_emitter (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  fsce_pkg::t_in     i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output fsce_pkg::t_out    o_data
);
    import fsce_pkg::*;

    t_state             r_state, n_state;
    t_mode              r_mode, n_mode;
    logic [3:0]         r_width, n_width;
    logic [3:0]         r_dw, n_dw;
    t_kind              r_kind, n_kind;
    logic [7:0]         r_char, n_char;
    logic [7:0]         r_pre0, n_pre0;
    logic [7:0]         r_pre1, n_pre1;
    logic [1:0]         r_pre_cnt, n_pre_cnt;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic               r_started, n_started;
    logic [BCD_W-1:0]   r_dig, n_dig;
    logic               r_o_vld, n_o_vld;
    t_out               r_o, n_o;

    logic [7:0]         w_fc;
    logic [ARG_W-1:0]   w_arg;
    logic               w_is_digit;
    logic               w_conv;
    logic [3:0]         w_eff;
    logic               w_slot;
    logic [3:0]         w_nib;
    logic [7:0]         w_dchar;
    logic               w_emit_last;

    logic               bcd_start;
    logic [ARG_W-1:0]   bcd_value;
    logic               bcd_busy;
    logic [BCD_W-1:0]   bcd_digits;

    fsce_bcd u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (bcd_start),
        .i_value (bcd_value),
        .o_busy  (bcd_busy),
        .o_bcd   (bcd_digits)
    );

    // request decode helpers
    assign w_fc       = i_data.format_byte;
    assign w_arg      = i_data.arg_value;
    assign w_is_digit = (w_fc >= CH_0) && (w_fc <= CH_9);
    assign w_conv     = (r_mode == M_SPEC) || ((r_mode == M_PCT) && !w_is_digit);
    assign w_eff      = (r_mode == M_PCT) ? 4'd1 : r_width;
    assign w_slot     = !r_o_vld || !i_stall;

    // current digit and its character
    assign w_nib   = r_dig[{r_idx, 2'b00} +: 4];
    assign w_dchar = (w_nib > NIB_MAX) ? (CH_A - 8'd10 + {4'b0000, w_nib})
                                       : (CH_0 + {4'b0000, w_nib});

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_width     = r_width;
        n_dw        = r_dw;
        n_kind      = r_kind;
        n_char      = r_char;
        n_pre0      = r_pre0;
        n_pre1      = r_pre1;
        n_pre_cnt   = r_pre_cnt;
        n_idx       = r_idx;
        n_started   = r_started;
        n_dig       = r_dig;
        n_o_vld     = r_o_vld && i_stall;
        n_o         = r_o;
        bcd_start   = 1'b0;
        bcd_value   = w_arg;
        w_emit_last = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_started = 1'b0;
                    n_char    = w_fc;
                    n_kind    = K_CHAR;
                    n_pre_cnt = 2'd0;
                    if (w_fc == CH_NUL) begin
                        // end of format
                        n_mode  = M_PLAIN;
                        n_width = '0;
                    end else if (w_conv) begin
                        if (w_fc == CH_LC_L) begin
                            n_mode  = M_SPEC;
                            n_width = LONG_WIDTH;
                        end else begin
                            n_mode  = M_PLAIN;
                            n_width = '0;
                            n_dw    = w_eff;
                            n_state = S_BODY;
                            priority if (w_fc == CH_LC_U) begin
                                n_kind    = K_DEC;
                                n_idx     = IDX_W'(BCD_DIGITS - 1);
                                bcd_start = 1'b1;
                                n_state   = S_WAIT;
                            end else if (w_fc == CH_LC_D) begin
                                n_kind    = K_DEC;
                                n_idx     = IDX_W'(BCD_DIGITS - 1);
                                bcd_start = 1'b1;
                                n_state   = S_WAIT;
                                if (w_arg[ARG_W-1]) begin
                                    bcd_value = (~w_arg) + 1'b1;
                                    n_pre0    = CH_MINUS;
                                    n_pre_cnt = 2'd1;
                                    n_state   = S_PRE;
                                end
                            end else if (w_fc == CH_LC_C) begin
                                n_char = w_arg[7:0];
                            end else if ((w_fc == CH_LC_X) || (w_fc == CH_UC_X)) begin
                                n_kind = K_HEX;
                                n_dig  = {{(BCD_W - ARG_W){1'b0}}, w_arg};
                                n_idx  = IDX_W'(w_eff - 4'd1);
                                if (w_eff == 4'd1) begin
                                    n_pre0    = CH_0;
                                    n_pre1    = w_fc;
                                    n_pre_cnt = 2'd2;
                                    n_state   = S_PRE;
                                end
                            end else begin
                                n_char = w_fc;
                            end
                        end
                    end else if (r_mode == M_PCT) begin
                        // width digit straight after the percent sign
                        n_width = w_fc[3:0];
                        n_mode  = (w_fc[3:0] != 4'd0) ? M_SPEC : M_PLAIN;
                    end else begin
                        n_mode = M_PLAIN;
                        if (w_fc == CH_PCT) begin
                            n_mode = M_PCT;
                        end else if (w_fc == CH_LF) begin
                            n_pre0    = CH_CR;
                            n_pre_cnt = 2'd1;
                            n_state   = S_PRE;
                        end else begin
                            n_state = S_BODY;
                        end
                    end
                end
            end

            S_PRE: begin
                if (w_slot) begin
                    n_o_vld        = 1'b1;
                    n_o.out_char   = r_pre0;
                    n_o.last_char  = 1'b0;
                    n_pre0         = r_pre1;
                    n_pre_cnt      = r_pre_cnt - 2'd1;
                    if (r_pre_cnt == 2'd1) begin
                        n_state = (r_kind == K_DEC) ? S_WAIT : S_BODY;
                    end
                end
            end

            S_WAIT: begin
                if (!bcd_busy) begin
                    n_dig   = bcd_digits;
                    n_state = S_BODY;
                end
            end

            S_BODY: begin
                if (r_kind == K_CHAR) begin
                    if (w_slot) begin
                        n_o_vld       = 1'b1;
                        n_o.out_char  = r_char;
                        n_o.last_char = 1'b1;
                        w_emit_last   = 1'b1;
                        n_state       = S_IDLE;
                    end
                end else if ((r_kind == K_DEC) && !r_started && (r_idx != '0)
                             && ({1'b0, r_idx} >= {1'b0, r_dw}) && (w_nib == 4'd0)) begin
                    // leading zero beyond the minimum width
                    n_idx = r_idx - 1'b1;
                end else if (w_slot) begin
                    n_o_vld       = 1'b1;
                    n_o.out_char  = w_dchar;
                    n_o.last_char = (r_idx == '0);
                    w_emit_last   = (r_idx == '0);
                    n_started     = 1'b1;
                    if (r_idx == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx - 1'b1;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode  <= M_PLAIN;
            r_width <= '0;
            r_o_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_width <= n_width;
            r_o_vld <= n_o_vld;
        end
        r_dw      <= n_dw;
        r_kind    <= n_kind;
        r_char    <= n_char;
        r_pre0    <= n_pre0;
        r_pre1    <= n_pre1;
        r_pre_cnt <= n_pre_cnt;
        r_idx     <= n_idx;
        r_started <= n_started;
        r_dig     <= n_dig;
        r_o       <= n_o;
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_o_vld;
    assign o_data  = r_o;

    // the converter is free whenever a new request comes in
    a_bcd_free_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |-> !bcd_busy)
        else $error("decimal converter busy at request accept");

    // digits are only read once the conversion has finished
    a_bcd_done_in_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BODY && r_kind == K_DEC) |-> !bcd_busy)
        else $error("decimal digits read during conversion");

    // the final character of a request frees the block
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit_last |=> (r_state == S_IDLE))
        else $error("block not idle after final character");

    // hex digit index stays within the nine-digit limit
    a_hex_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BODY && r_kind == K_HEX) |-> (r_idx <= IDX_W'(8)))
        else $error("hex digit index out of range");

    // prefix state always has a character pending
    a_pre_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PRE) |-> (r_pre_cnt != 2'd0))
        else $error("prefix state with nothing to send");

endmodule

[rtl/fsce_bcd.sv]
module fsce_bcd (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [fsce_pkg::ARG_W-1:0]    i_value,
    output logic                          o_busy,
    output logic [fsce_pkg::BCD_W-1:0]    o_bcd
);
    import fsce_pkg::*;

    localparam int CNT_W = $clog2(ARG_W);

    logic               r_busy, n_busy;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [ARG_W-1:0]   r_bin, n_bin;
    logic [BCD_W-1:0]   r_bcd, n_bcd;
    logic [BCD_W-1:0]   w_adj;

    // add-3 correction on every decimal digit of five or more
    always_comb begin
        for (int i = 0; i < BCD_DIGITS; i++) begin
            w_adj[i*4 +: 4] = (r_bcd[i*4 +: 4] > 4'd4) ? (r_bcd[i*4 +: 4] + 4'd3)
                                                       : r_bcd[i*4 +: 4];
        end
    end

    // one binary bit shifted into the decimal store per cycle
    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_bin  = r_bin;
        n_bcd  = r_bcd;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_bin  = i_value;
            n_bcd  = '0;
        end else if (r_busy) begin
            n_bcd = {w_adj[BCD_W-2:0], r_bin[ARG_W-1]};
            n_bin = {r_bin[ARG_W-2:0], 1'b0};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(ARG_W - 1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_cnt <= n_cnt;
        r_bin <= n_bin;
        r_bcd <= n_bcd;
    end

    assign o_busy = r_busy;
    assign o_bcd  = r_bcd;

endmodule
